>>> sv/stmb_pkg.sv
// shared constants for the sparse table min builder
// no dependencies; every other file except stmb_ram refers to it by scoped names
package stmb_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int LEVELS_DEF  = 11;

  localparam int VALUE_W = 32;
  localparam int START_W = 10;
  localparam int LEVEL_W = 4;
  localparam int INDEX_W = 10;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

>>> sv/stmb_if.sv
// valid/ready channel interfaces for the input elements and the result words
// depends on stmb_pkg for the field widths
interface stmb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [stmb_pkg::VALUE_W-1:0]  value;
  logic                                 last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface stmb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [stmb_pkg::START_W-1:0]         start_index;
  logic [stmb_pkg::LEVEL_W-1:0]         level;
  logic [stmb_pkg::INDEX_W-1:0]         min_index;
  logic signed [stmb_pkg::VALUE_W-1:0]  min_value;
  logic                                 overflow;
  logic                                 run_end;

  modport source (output valid, output start_index, output level, output min_index,
                  output min_value, output overflow, output run_end, input ready);
  modport sink   (input valid, input start_index, input level, input min_index,
                  input min_value, input overflow, input run_end, output ready);
endinterface

>>> sv/stmb_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module stmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/stmb_front.sv
// front end: accepts elements, tracks the array position and flags overflow
// depends on stmb_pkg and stmb_if; feeds stmb_queue
module stmb_front #(
  parameter int MAX_LEN = stmb_pkg::MAX_LEN_DEF,
  parameter int IW      = $clog2(MAX_LEN),
  parameter int QW      = IW + stmb_pkg::VALUE_W + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  stmb_in_if.sink       in_ch,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_push_data
);

  logic [IW:0] pos_r;
  logic [IW:0] pos_nxt;
  logic        ovf;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign ovf         = (pos_r >= (IW+1)'(MAX_LEN));

  // job word: overflow, last, position, value
  assign q_push_data = {ovf, in_ch.last_item, pos_r[IW-1:0], in_ch.value};

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (in_ch.last_item) begin
        pos_nxt = '0;
      end else if (!ovf) begin
        pos_nxt = pos_r + (IW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

>>> sv/stmb_queue.sv
// short fifo of classified jobs between the front and the back end
// depends on stmb_pkg for its depth
module stmb_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  localparam int QD = stmb_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(QD);

  logic [W-1:0]  entry_r [QD];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic [PW:0]   cnt_nxt;

  assign full       = (cnt_r == (PW+1)'(QD));
  assign head_valid = (cnt_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> sv/stmb_back.sv
// back end: walks the levels of one element, merges halves through the
// argmin/min table in stmb_ram and drives the result register
// depends on stmb_pkg, stmb_if and stmb_ram
module stmb_back #(
  parameter int MAX_LEN = stmb_pkg::MAX_LEN_DEF,
  parameter int LEVELS  = stmb_pkg::LEVELS_DEF,
  parameter int IW      = $clog2(MAX_LEN),
  parameter int QW      = IW + stmb_pkg::VALUE_W + 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  stmb_out_if.source    out_ch
);

  localparam int VW    = stmb_pkg::VALUE_W;
  localparam int LVW   = $clog2(LEVELS);
  localparam int AW    = LVW + IW;
  localparam int MW    = IW + VW;
  localparam int DEPTH = LEVELS * (2 ** IW);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t               state_r;
  logic [IW-1:0]        p_r;
  logic signed [VW-1:0] v_r;
  logic                 ovf_r;
  logic [LVW-1:0]       lev_r;
  logic [LVW-1:0]       tag_r;
  logic [IW-1:0]        cur_idx_r;
  logic signed [VW-1:0] cur_val_r;

  logic                         o_valid_r;
  logic [stmb_pkg::START_W-1:0] o_start_r;
  logic [stmb_pkg::LEVEL_W-1:0] o_level_r;
  logic [stmb_pkg::INDEX_W-1:0] o_idx_r;
  logic signed [VW-1:0]         o_val_r;
  logic                         o_ovf_r;
  logic                         o_end_r;

  logic                 oslot;
  logic                 lev0;
  logic [IW:0]          p1;
  logic [LVW:0]         lev1;
  logic                 fin;
  logic                 rd_ok;
  logic                 emit;
  logic [MW-1:0]        rd_data;
  logic [IW-1:0]        left_idx;
  logic signed [VW-1:0] left_val;
  logic [IW-1:0]        m_idx;
  logic signed [VW-1:0] m_val;
  logic [IW-1:0]        s_idx;
  logic [LVW-1:0]       tgt;
  logic [LVW-1:0]       tm1;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [MW-1:0]        wr_data;

  assign oslot = !o_valid_r || out_ch.ready;
  assign lev0  = (lev_r == '0);
  assign p1    = {1'b0, p_r} + (IW+1)'(1);
  assign lev1  = {1'b0, lev_r} + (LVW+1)'(1);
  // last level: top of the table, or the next interval would start before 0
  assign fin   = (lev1 == (LVW+1)'(LEVELS)) || ((p1 >> lev1) == '0);
  assign rd_ok = (tag_r == lev_r);

  assign left_idx = rd_data[MW-1:VW];
  assign left_val = $signed(rd_data[VW-1:0]);

  // left half wins only when strictly smaller
  always_comb begin
    if (left_val < cur_val_r) begin
      m_idx = left_idx;
      m_val = left_val;
    end else begin
      m_idx = cur_idx_r;
      m_val = cur_val_r;
    end
  end

  assign s_idx = p_r - (IW'(1) << lev_r) + IW'(1);

  assign emit  = (state_r == ST_RUN) && oslot && (ovf_r || lev0 || rd_ok);
  assign q_pop = (state_r == ST_IDLE) && q_valid;

  // read one level ahead so a level retires every cycle while out_ch is not stalled
  assign tgt     = (emit && !ovf_r && !fin) ? lev_r + LVW'(1) : lev_r;
  assign tm1     = tgt - LVW'(1);
  assign rd_addr = {tm1, p_r - (IW'(1) << tm1)};

  assign wr_en   = emit && !ovf_r;
  assign wr_addr = {lev_r, p_r};
  assign wr_data = lev0 ? {p_r, v_r} : {m_idx, m_val};

  stmb_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_tab (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      v_r    <= $signed(q_data[VW-1:0]);
      p_r    <= q_data[VW+IW-1:VW];
      ovf_r  <= q_data[VW+IW+1];
    end
    if (emit && !ovf_r) begin
      if (lev0) begin
        cur_idx_r <= p_r;
        cur_val_r <= v_r;
      end else begin
        cur_idx_r <= m_idx;
        cur_val_r <= m_val;
      end
    end
    if (emit) begin
      if (ovf_r) begin
        o_start_r <= '0;
        o_level_r <= '0;
        o_idx_r   <= '0;
        o_val_r   <= '0;
        o_ovf_r   <= 1'b1;
        o_end_r   <= 1'b1;
      end else begin
        o_start_r <= stmb_pkg::START_W'(lev0 ? p_r : s_idx);
        o_level_r <= stmb_pkg::LEVEL_W'(lev_r);
        o_idx_r   <= stmb_pkg::INDEX_W'(lev0 ? p_r : m_idx);
        o_val_r   <= lev0 ? v_r : m_val;
        o_ovf_r   <= 1'b0;
        o_end_r   <= fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lev_r     <= '0;
      tag_r     <= '0;
      o_valid_r <= 1'b0;
    end else begin
      tag_r <= tgt;
      if (emit) begin
        o_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          lev_r <= '0;
          if (q_pop) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (emit) begin
            if (ovf_r || fin) begin
              state_r <= ST_IDLE;
              lev_r   <= '0;
            end else begin
              lev_r <= lev_r + LVW'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
          lev_r   <= '0;
        end
      endcase
    end
  end

  assign out_ch.valid       = o_valid_r;
  assign out_ch.start_index = o_start_r;
  assign out_ch.level       = o_level_r;
  assign out_ch.min_index   = o_idx_r;
  assign out_ch.min_value   = o_val_r;
  assign out_ch.overflow    = o_ovf_r;
  assign out_ch.run_end     = o_end_r;

endmodule

>>> sv/sparse_table_min_builder.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    value (s32), last_item
// out_ch    out  valid/ready    start_index, level, min_index, min_value, overflow, run_end
//
// an element at position p gives n = min(LEVELS, floor(log2(p+1)) + 1) results, one per cycle
// while out_ch is not stalled; a dropped element gives one overflow word
// the rate is set by the single read and write port of the level table ram
// reset is synchronous and clears control only; the table needs no clearing
// the queue keeps taking elements while the back end or out_ch is stalled, until it is full
// depends on stmb_pkg, stmb_if, stmb_front, stmb_queue, stmb_back
module sparse_table_min_builder #(
  parameter int MAX_LEN = stmb_pkg::MAX_LEN_DEF,
  parameter int LEVELS  = stmb_pkg::LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  stmb_in_if.sink    in_ch,
  stmb_out_if.source out_ch
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int QW = IW + stmb_pkg::VALUE_W + 2;

  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_data;

  stmb_front #(
    .MAX_LEN (MAX_LEN),
    .IW      (IW),
    .QW      (QW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  stmb_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_data)
  );

  stmb_back #(
    .MAX_LEN (MAX_LEN),
    .LEVELS  (LEVELS),
    .IW      (IW),
    .QW      (QW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// testbench for sparse_table_min_builder: directed table, then random arrays
// depends on stmb_pkg, stmb_if and the block; expected words: own predictor and directed table
module tb;

  localparam int VALUE_W      = stmb_pkg::VALUE_W;
  localparam int START_W      = stmb_pkg::START_W;
  localparam int LEVEL_W      = stmb_pkg::LEVEL_W;
  localparam int INDEX_W      = stmb_pkg::INDEX_W;
  localparam int MAX_LEN      = stmb_pkg::MAX_LEN_DEF;
  localparam int LEVELS       = stmb_pkg::LEVELS_DEF;
  localparam int RANDOM_ITEMS = 165;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [START_W-1:0]        start_index;
    logic [LEVEL_W-1:0]        level;
    logic [INDEX_W-1:0]        min_index;
    logic signed [VALUE_W-1:0] min_value;
    logic                      overflow;
    logic                      run_end;
  } interval_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
    logic                      has_want;
    interval_t                 want;
  } stim_row_t;

  localparam interval_t NO_WANT = '0;
  localparam interval_t DROPPED = '{10'd0, 4'd0, 10'd0, 32'sd0, 1'b1, 1'b1};

  // typed expectations only for single-word rows: first element of an array
  localparam stim_row_t DIRECTED [15] = '{
    '{VMAX,   1'b1, 1'b1, '{10'd0, 4'd0, 10'd0, VMAX, 1'b0, 1'b1}},
    '{VMIN,   1'b1, 1'b1, '{10'd0, 4'd0, 10'd0, VMIN, 1'b0, 1'b1}},
    // ties at level 1, right half must win
    '{32'sd5, 1'b0, 1'b1, '{10'd0, 4'd0, 10'd0, 32'sd5, 1'b0, 1'b1}},
    '{32'sd5, 1'b0, 1'b0, NO_WANT},
    '{32'sd3, 1'b0, 1'b0, NO_WANT},
    '{32'sd3, 1'b1, 1'b0, NO_WANT},
    // sign extremes across eight elements, up to level 3
    '{VMIN,   1'b0, 1'b1, '{10'd0, 4'd0, 10'd0, VMIN, 1'b0, 1'b1}},
    '{VMAX,   1'b0, 1'b0, NO_WANT},
    '{VMIN,   1'b0, 1'b0, NO_WANT},
    '{32'sd0, 1'b0, 1'b0, NO_WANT},
    '{-32'sd1, 1'b0, 1'b0, NO_WANT},
    '{32'sd1, 1'b0, 1'b0, NO_WANT},
    '{32'sd0, 1'b0, 1'b0, NO_WANT},
    '{-32'sd1, 1'b1, 1'b0, NO_WANT},
    // one-word array right after a closed one
    '{32'sd42, 1'b1, 1'b1, '{10'd0, 4'd0, 10'd0, 32'sd42, 1'b0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n;

  stmb_in_if  in_ch ();
  stmb_out_if out_ch ();

  sparse_table_min_builder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [VALUE_W-1:0] elem_mem [MAX_LEN];
  logic [INDEX_W-1:0]        argmin_mem [MAX_LEN][LEVELS];
  int                        fill_pos = 0;

  interval_t interval_q [$];
  int        err_count   = 0;
  int        cycle_count = 0;
  int        in_calm     = 0;
  int        out_calm    = 0;

  task automatic flag_error(input string msg);
    err_count++;
    $display("tb: mismatch: %s", msg);
  endtask

  // wait before the next word; now and then a stretch with no idling
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic signed [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 6))
      0:       return VMAX;
      1:       return VMIN;
      2, 3:    return VALUE_W'(int'($urandom_range(0, 6)) - 3);
      default: return $urandom();
    endcase
  endfunction

  // stores the element and works out every interval that it completes; past MAX_LEN, a dropped word
  function automatic void build_intervals(input logic signed [VALUE_W-1:0] v,
                                          input logic closes, input bit keep);
    int        p, j, n, s, li, ri, m;
    interval_t res [LEVELS];
    p = fill_pos;
    if (p >= MAX_LEN) begin
      if (keep) interval_q.push_back(DROPPED);
      if (closes) fill_pos = 0;
      return;
    end
    elem_mem[p]      = v;
    argmin_mem[p][0] = INDEX_W'(p);
    res[0] = '{START_W'(p), LEVEL_W'(0), INDEX_W'(p), v, 1'b0, 1'b0};
    n = 1;
    for (j = 1; j < LEVELS && (1 << j) <= p + 1; j++) begin
      s  = p - (1 << j) + 1;
      li = int'(argmin_mem[s][j-1]);
      ri = int'(argmin_mem[s + (1 << (j - 1))][j-1]);
      // left half only when strictly smaller
      m  = (elem_mem[li] < elem_mem[ri]) ? li : ri;
      argmin_mem[s][j] = INDEX_W'(m);
      res[n] = '{START_W'(s), LEVEL_W'(j), INDEX_W'(m), elem_mem[m], 1'b0, 1'b0};
      n++;
    end
    res[n-1].run_end = 1'b1;
    if (keep) begin
      for (j = 0; j < n; j++) interval_q.push_back(res[j]);
    end
    fill_pos = closes ? 0 : p + 1;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic closes,
                              input logic has_want, input interval_t want);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.last_item <= closes;
    do @(posedge clk); while (!in_ch.ready);
    build_intervals(v, closes, !has_want);
    if (has_want) interval_q.push_back(want);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                             input logic [VALUE_W-1:0] want, input interval_t ref_word);
    if (got !== want)
      flag_error($sformatf("%s got %0h expected %0h (start %0d level %0d)", name, got, want,
                           ref_word.start_index, ref_word.level));
  endtask

  always @(posedge clk) begin : result_check
    interval_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.start_index, out_ch.level, out_ch.min_index, out_ch.min_value,
              out_ch.overflow, out_ch.run_end};
      if (interval_q.size() == 0) begin
        flag_error($sformatf("word with nothing expected, start %0d level %0d",
                             got.start_index, got.level));
      end else begin
        want = interval_q.pop_front();
        check_field("start_index", VALUE_W'(got.start_index), VALUE_W'(want.start_index),
                    want);
        check_field("level", VALUE_W'(got.level), VALUE_W'(want.level), want);
        check_field("min_index", VALUE_W'(got.min_index), VALUE_W'(want.min_index), want);
        check_field("min_value", got.min_value, want.min_value, want);
        check_field("overflow", VALUE_W'(got.overflow), VALUE_W'(want.overflow), want);
        check_field("run_end", VALUE_W'(got.run_end), VALUE_W'(want.run_end), want);
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    do @(negedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int        sent, len, k;
    stim_row_t row;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.value     = '0;
    in_ch.last_item = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      send_element(row.value, row.last_item, row.has_want, row.want);
    end

    // random arrays, mostly short, a few longer ones for the upper levels
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 20);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      for (k = 0; k < len; k++) send_element(draw_value(), k == len - 1, 1'b0, NO_WANT);
      sent += len;
    end
    in_ch.valid <= 1'b0;

    while (interval_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && interval_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
